### sv/fpdt_pkg.sv
package fpdt_pkg;

	localparam int VALUE_W            = 64;
	localparam int BCD_DIGITS         = 19;
	localparam int BCD_W              = 4 * BCD_DIGITS;
	localparam int FB_W               = 5;
	localparam int CNT_W              = 7;
	localparam int DCNT_W             = 5;
	localparam int CHAR_W             = 7;
	localparam int FALLBACK_FRAC_BITS = 8;

	localparam logic [FB_W-1:0]   FRAC_BITS_RESET = 5'd8;

	// register indexes
	localparam logic REG_FRAC_BITS = 1'b0;

	// character codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_DOT   = 7'h2E;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_INT,
		ST_DOT,
		ST_FRAC
	} emit_state_t;

	typedef struct packed {
		logic done;
		logic neg;
	} conv_status_t;

endpackage

### sv/fpdt_dabble.sv
module fpdt_dabble import fpdt_pkg::*; #(
	parameter int FRAC_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [VALUE_W-1:0]   value,
	input  logic [FB_W-1:0]      fb,
	output conv_status_t         status,
	output logic [BCD_W-1:0]     bcd,
	output logic [FRAC_W-1:0]    frac
);

	logic                busy_q;
	logic                done_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [VALUE_W-1:0]  mag_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [BCD_W-1:0]    bcd_adj;
	logic [CNT_W-1:0]    int_bits;
	logic                in_neg;
	logic [VALUE_W-1:0]  in_mag;

	assign in_neg   = value[VALUE_W-1];
	assign in_mag   = in_neg ? (~value + VALUE_W'(1)) : value;
	assign int_bits = CNT_W'(VALUE_W) - CNT_W'(fb);

	// add-3 on every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= in_neg;
			mag_q  <= in_mag;
			bcd_q  <= '0;
			frac_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			if (cnt_q < int_bits)
				bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
			else
				frac_q <= {frac_q[FRAC_W-2:0], mag_q[VALUE_W-1]};
		end
	end

	assign status.done = done_q;
	assign status.neg  = neg_q;
	assign bcd         = bcd_q;
	assign frac        = frac_q;

endmodule

### sv/fpdt_emit.sv
module fpdt_emit import fpdt_pkg::*; #(
	parameter int FRAC_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              start,
	input  conv_status_t      status,
	input  logic [BCD_W-1:0]  bcd,
	input  logic [FRAC_W-1:0] frac,
	input  logic [FB_W-1:0]   fb,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	localparam int PROD_W = FRAC_W + 4;

	emit_state_t         state_q, state_d;
	logic [BCD_W-1:0]    bcd_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic [FB_W-1:0]     fcnt_q;
	logic                m_tvalid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	logic                out_free;
	logic                emit;
	logic                emit_last;
	logic                skip;
	logic [CHAR_W-1:0]   emit_char;
	logic [3:0]          top_digit;
	logic                top_zero;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   prod_sh;
	logic [3:0]          frac_digit;
	logic [FRAC_W-1:0]   frac_next;

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign start     = s_tvalid && s_tready;
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign top_zero  = (top_digit == 4'd0);
	assign skip      = top_zero && (dcnt_q > DCNT_W'(1));

	// next fraction digit: frac * 10, integer part above fb, rest stays
	assign prod       = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);
	assign prod_sh    = prod >> fb;
	assign frac_digit = prod_sh[3:0];
	assign frac_next  = prod[FRAC_W-1:0] & ~({FRAC_W{1'b1}} << fb);

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_char = ASCII_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_d = ST_CONV;
			end
			ST_CONV: begin
				if (status.done)
					state_d = status.neg ? ST_SIGN : ST_SKIP;
			end
			ST_SIGN: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = ASCII_MINUS;
					state_d   = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!skip)
					state_d = ST_INT;
			end
			ST_INT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = ASCII_ZERO + CHAR_W'(top_digit);
					if (dcnt_q == DCNT_W'(1))
						state_d = ST_DOT;
				end
			end
			ST_DOT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = ASCII_DOT;
					state_d   = ST_FRAC;
				end
			end
			ST_FRAC: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = ASCII_ZERO + CHAR_W'(frac_digit);
					if (fcnt_q == FB_W'(1)) begin
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
		if (state_q == ST_CONV && status.done) begin
			bcd_q  <= bcd;
			frac_q <= frac;
			dcnt_q <= DCNT_W'(BCD_DIGITS);
			fcnt_q <= fb;
		end else if ((state_q == ST_SKIP && skip) || (state_q == ST_INT && emit)) begin
			bcd_q  <= {bcd_q[BCD_W-5:0], 4'b0};
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end else if (state_q == ST_FRAC && emit) begin
			frac_q <= frac_next;
			fcnt_q <= fcnt_q - FB_W'(1);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

endmodule

### sv/fixed_point_to_decimal_text.sv
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata[63:0] = value (signed fixed point)
// m_*       out  m_tvalid / m_tready    m_tdata[6:0] = char_code, m_tlast = last_char
// APB       in   psel/penable/pready    0x0: frac_bits[4:0]
//
// Each item is accepted, converted by bit-serial double dabble (one magnitude
// bit per cycle), handed off, then leading zero digits are skipped (up to 18)
// and characters go out one per cycle when the sink keeps up. At most 19 digit
// positions are skipped or sent, plus sign, dot and up to 16 fraction digits;
// the 64-step binary to BCD loop dominates.
// s_tready is high only between items; the last character may still sit in the
// output register while the next item is accepted. m_tready low stalls output.
// Reset (arst_n) clears control state and sets frac_bits to 8.
module fixed_point_to_decimal_text import fpdt_pkg::*; #(
	parameter int MAX_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	// result item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
	output logic        m_tlast,   // last_char
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// fraction register must hold the fallback width too
	localparam int FRAC_W = (MAX_FRAC_BITS > FALLBACK_FRAC_BITS) ?
	                        MAX_FRAC_BITS : FALLBACK_FRAC_BITS;

	logic [FB_W-1:0]   frac_bits_q;
	logic [FB_W-1:0]   eff_fb;
	logic              reg_sel;
	logic              start;
	conv_status_t      conv_status;
	logic [BCD_W-1:0]  conv_bcd;
	logic [FRAC_W-1:0] conv_frac;

	// APB register file: one register, decoded on paddr[2] only
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_FRAC_BITS);
	assign prdata  = reg_sel ? {27'b0, frac_bits_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frac_bits_q <= FRAC_BITS_RESET;
		else if (psel && penable && pwrite && pready && reg_sel)
			frac_bits_q <= pwdata[FB_W-1:0];
	end

	// zero or too many fraction bits falls back to 8
	assign eff_fb = (frac_bits_q == '0 || frac_bits_q > FB_W'(MAX_FRAC_BITS)) ?
	                FB_W'(FALLBACK_FRAC_BITS) : frac_bits_q;

	// magnitude, binary to BCD on the integer bits, fraction bits collected
	fpdt_dabble #(
		.FRAC_W (FRAC_W)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (s_tdata),
		.fb     (eff_fb),
		.status (conv_status),
		.bcd    (conv_bcd),
		.frac   (conv_frac)
	);

	// character sequencer and output register
	fpdt_emit #(
		.FRAC_W (FRAC_W)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.start    (start),
		.status   (conv_status),
		.bcd      (conv_bcd),
		.frac     (conv_frac),
		.fb       (eff_fb),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// an accepted item closes the input until its last character is emitted
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in flight");

	// a new item is only taken once only the final character may be pending
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && m_tvalid) |-> m_tlast)
		else $error("input ready with text still being sent");

	// the text always ends in a fraction digit
	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[6:0] >= ASCII_ZERO &&
		 m_tdata[6:0] <= ASCII_ZERO + 7'd9))
		else $error("final character is not a digit");

endmodule
